// File: design/fcte_pkg.sv
package fcte_pkg;

  typedef enum logic [1:0] {
    FUNC_GET = 2'd0,
    FUNC_PUT = 2'd1,
    FUNC_DEL = 2'd2,
    FUNC_CLR = 2'd3
  } func_e;

  localparam logic [30:0] NEVER_DEADLINE = 31'h7FFF_FFFF;
  localparam int unsigned STAMP_W = 32;

  typedef struct packed {
    logic [1:0]  func;
    logic [30:0] now;
    logic [30:0] deadline;
  } item_ctl_t;

endpackage

// File: design/fcte_store.sv
module fcte_store #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned KW = 32,
  parameter int unsigned VW = 32,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                         clk_i,
  input  logic [AW-1:0]                raddr_i,
  output logic [KW-1:0]                rkey_o,
  output logic [VW-1:0]                rdata_o,
  output logic [30:0]                  rdl_o,
  output logic [fcte_pkg::STAMP_W-1:0] rstamp_o,
  input  logic                         we_i,
  input  logic                         wkey_en_i,
  input  logic [AW-1:0]                waddr_i,
  input  logic [KW-1:0]                wkey_i,
  input  logic [VW-1:0]                wdata_i,
  input  logic [30:0]                  wdl_i,
  input  logic [fcte_pkg::STAMP_W-1:0] wstamp_i
);
  logic [KW-1:0]                key_mem   [DEPTH];
  logic [VW-1:0]                data_mem  [DEPTH];
  logic [30:0]                  dl_mem    [DEPTH];
  logic [fcte_pkg::STAMP_W-1:0] stamp_mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      data_mem[waddr_i] <= wdata_i;
      dl_mem[waddr_i]   <= wdl_i;
      if (wkey_en_i) begin
        key_mem[waddr_i]   <= wkey_i;
        stamp_mem[waddr_i] <= wstamp_i;
      end
    end
    rkey_o   <= key_mem[raddr_i];
    rdata_o  <= data_mem[raddr_i];
    rdl_o    <= dl_mem[raddr_i];
    rstamp_o <= stamp_mem[raddr_i];
  end
endmodule

// File: design/fifo_cache_with_ttl_expiry_top.sv
// channel  direction  signals
// in       input      in_valid_i / in_ready_o, func_i key_i value_i ttl_i now_i
// out      output     out_valid_o / out_ready_i, found_o read_value_o evicted_o
//                     evicted_key_o occupancy_o
// cfg      input      cfg_valid_i / cfg_ready_o, cfg_data_i (capacity)
// Get, put and delete scan every entry before giving a valid result:
// one memory read per entry through the single read port of the entry store, then
// a write step. Clear skips the scan. One item at a time; while a result waits in
// the output register the next beat is held off, unless the result is taken in the
// same cycle. No clearing pass after reset: valid bits sit in flip-flops.
module fifo_cache_with_ttl_expiry_top #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned KEY_WIDTH = 32,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  func_i,
  input  logic [31:0] key_i,
  input  logic [31:0] value_i,
  input  logic signed [31:0] ttl_i,
  input  logic [30:0] now_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        found_o,
  output logic [31:0] read_value_o,
  output logic        evicted_o,
  output logic [31:0] evicted_key_o,
  output logic [4:0]  occupancy_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [4:0]  cfg_data_i
);
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned SW = fcte_pkg::STAMP_W;

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_LAST, S_WRITE, S_DONE} state_e;

  state_e                 state_q;
  fcte_pkg::item_ctl_t    ctl_q;
  logic [KEY_WIDTH-1:0]   key_q;
  logic [VALUE_WIDTH-1:0] val_q;
  logic [4:0]             cap_q;
  logic [DEPTH-1:0]       valid_q;
  logic [SW-1:0]          ctr_q;
  logic [CW-1:0]          cnt_q;
  logic [AW-1:0]          raddr_q;
  logic [AW-1:0]          cidx_q;
  logic                   cmp_q;
  logic                   hit_q;
  logic [AW-1:0]          hidx_q;
  logic [VALUE_WIDTH-1:0] hval_q;
  logic                   old_q;
  logic [AW-1:0]          oidx_q;
  logic [SW-1:0]          oage_q;
  logic [KEY_WIDTH-1:0]   okey_q;
  logic                   free_q;
  logic [AW-1:0]          fidx_q;

  logic [KEY_WIDTH-1:0]   rkey;
  logic [VALUE_WIDTH-1:0] rdata;
  logic [30:0]            rdl;
  logic [SW-1:0]          rstamp;
  logic                   we, wkey_en;
  logic [AW-1:0]          waddr;

  logic [4:0] cap_eff;
  always_comb begin
    if (cap_q == 5'd0) cap_eff = 5'd1;
    else if ({{(32-5){1'b0}}, cap_q} > DEPTH) cap_eff = 5'(DEPTH);
    else cap_eff = cap_q;
  end

  logic [31:0] sum_w;
  logic [30:0] dl_w;
  always_comb begin
    sum_w = {1'b0, now_i} + {1'b0, ttl_i[30:0]};
    if (ttl_i[31] || sum_w[31]) dl_w = fcte_pkg::NEVER_DEADLINE;
    else dl_w = sum_w[30:0];
  end

  logic is_sweep;
  assign is_sweep = (ctl_q.func == fcte_pkg::FUNC_GET) || (ctl_q.func == fcte_pkg::FUNC_PUT);

  // per-entry evaluation of registered read data
  logic          e_live, e_exp, e_match;
  logic [SW-1:0] e_age;
  always_comb begin
    e_live  = valid_q[cidx_q];
    e_exp   = is_sweep && (rdl < ctl_q.now);
    e_match = e_live && !e_exp && (rkey == key_q);
    e_age   = ctr_q - rstamp;
  end

  // put decisions after scan
  logic need_evict, do_ins;
  logic [AW-1:0] ins_idx;
  always_comb begin
    need_evict = !hit_q && ({{(32-CW){1'b0}}, cnt_q} + 1 > {27'd0, cap_eff}) && old_q;
    if (free_q) ins_idx = fidx_q;
    else ins_idx = oidx_q;
    do_ins = !hit_q && (free_q || need_evict);
  end

  logic             put_evict;
  logic [DEPTH-1:0] ins_mask, evict_mask;
  always_comb begin
    put_evict  = (ctl_q.func == fcte_pkg::FUNC_PUT) && do_ins && need_evict;
    ins_mask   = '0;
    ins_mask[ins_idx] = 1'b1;
    evict_mask = '0;
    if (need_evict && free_q) evict_mask[oidx_q] = 1'b1;
  end

  logic out_set;
  assign out_set = (state_q == S_DONE) ||
                   ((state_q == S_IDLE) && in_valid_i && in_ready_o &&
                    (func_i == fcte_pkg::FUNC_CLR));

  assign in_ready_o  = (state_q == S_IDLE) && !(out_valid_o && !out_ready_i);
  assign cfg_ready_o = (state_q == S_IDLE);
  assign we      = (state_q == S_WRITE) && (ctl_q.func == fcte_pkg::FUNC_PUT) && (hit_q || do_ins);
  assign wkey_en = !hit_q;
  assign waddr   = hit_q ? hidx_q : ins_idx;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cap_q       <= 5'd16;
      valid_q     <= '0;
      ctr_q       <= '0;
      cnt_q       <= '0;
      out_valid_o <= 1'b0;
      cmp_q       <= 1'b0;
      raddr_q     <= '0;
      cidx_q      <= '0;
    end else begin
      if (out_set) out_valid_o <= 1'b1;
      else if (out_valid_o && out_ready_i) out_valid_o <= 1'b0;
      if (cfg_valid_i && cfg_ready_o) cap_q <= cfg_data_i;
      case (state_q)
        S_IDLE: begin
          if (in_valid_i && in_ready_o) begin
            ctl_q   <= '{func: func_i, now: now_i, deadline: dl_w};
            key_q   <= KEY_WIDTH'(key_i);
            val_q   <= VALUE_WIDTH'(value_i);
            hit_q   <= 1'b0;
            old_q   <= 1'b0;
            free_q  <= 1'b0;
            hval_q  <= '0;
            raddr_q <= '0;
            cmp_q   <= 1'b0;
            if (func_i == fcte_pkg::FUNC_CLR) begin
              valid_q <= '0;
              cnt_q   <= '0;
              found_o <= 1'b0;
              read_value_o <= '0;
              evicted_o <= 1'b0;
              evicted_key_o <= '0;
              occupancy_o <= 5'd0;
            end else begin
              state_q <= S_SCAN;
            end
          end
        end
        S_SCAN, S_LAST: begin
          cmp_q  <= (state_q == S_SCAN);
          cidx_q <= raddr_q;
          if (state_q == S_SCAN) begin
            if (raddr_q == AW'(DEPTH - 1)) state_q <= S_LAST;
            else raddr_q <= raddr_q + 1'b1;
          end else begin
            state_q <= S_WRITE;
          end
          if (cmp_q) begin
            if (e_live && e_exp) begin
              valid_q[cidx_q] <= 1'b0;
              cnt_q <= cnt_q - 1'b1;
            end
            if (e_match && !hit_q) begin
              hit_q  <= 1'b1;
              hidx_q <= cidx_q;
              hval_q <= rdata;
            end
            if (e_live && !e_exp && (!old_q || e_age > oage_q)) begin
              old_q  <= 1'b1;
              oidx_q <= cidx_q;
              oage_q <= e_age;
              okey_q <= rkey;
            end
            if ((!e_live || e_exp) && !free_q) begin
              free_q <= 1'b1;
              fidx_q <= cidx_q;
            end
          end
        end
        S_WRITE: begin
          state_q       <= S_DONE;
          found_o       <= hit_q && (ctl_q.func != fcte_pkg::FUNC_PUT);
          read_value_o  <= (ctl_q.func == fcte_pkg::FUNC_GET) ? 32'(hval_q) : '0;
          evicted_o     <= put_evict;
          evicted_key_o <= put_evict ? 32'(okey_q) : '0;
          case (ctl_q.func)
            fcte_pkg::FUNC_DEL: begin
              if (hit_q) begin
                valid_q[hidx_q] <= 1'b0;
                cnt_q <= cnt_q - 1'b1;
              end
            end
            fcte_pkg::FUNC_PUT: begin
              if (do_ins) begin
                valid_q <= (valid_q | ins_mask) & ~evict_mask;
                ctr_q   <= ctr_q + 1'b1;
                if (!need_evict) cnt_q <= cnt_q + 1'b1;
              end
            end
            default: ;
          endcase
        end
        S_DONE: begin
          occupancy_o <= 5'(cnt_q);
          state_q     <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  fcte_store #(.DEPTH(DEPTH), .KW(KEY_WIDTH), .VW(VALUE_WIDTH)) u_store (
    .clk_i     (clk_i),
    .raddr_i   (raddr_q),
    .rkey_o    (rkey),
    .rdata_o   (rdata),
    .rdl_o     (rdl),
    .rstamp_o  (rstamp),
    .we_i      (we),
    .wkey_en_i (wkey_en),
    .waddr_i   (waddr),
    .wkey_i    (key_q),
    .wdata_i   (val_q),
    .wdl_i     (ctl_q.deadline),
    .wstamp_i  (ctr_q)
  );

`ifndef NO_ASSERTIONS
  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (32'(cnt_q) == 32'($countones(valid_q))))
    else $error("count drifts from valid bits");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !in_ready_o && !cfg_ready_o)
    else $error("beat taken while busy");
  a_ev: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && evicted_o) |-> !found_o)
    else $error("eviction with hit");
`endif
endmodule

// File: tb/sv/tb_fifo_cache_with_ttl_expiry_top.sv
module tb_fifo_cache_with_ttl_expiry_top;

  localparam int unsigned DEPTH = 16;
  localparam int unsigned IDLE_LIMIT = 3000;
  localparam int unsigned DRAIN_CYCLES = 2 * DEPTH + 8;

  typedef struct packed {
    logic        found;
    logic [31:0] read_value;
    logic        evicted;
    logic [31:0] evicted_key;
    logic [4:0]  occupancy;
  } cache_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [1:0]  func_i;
  logic [31:0] key_i;
  logic [31:0] value_i;
  logic signed [31:0] ttl_i;
  logic [30:0] now_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic        found_o;
  logic [31:0] read_value_o;
  logic        evicted_o;
  logic [31:0] evicted_key_o;
  logic [4:0]  occupancy_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [4:0]  cfg_data_i;

  fifo_cache_with_ttl_expiry_top u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .func_i       (func_i),
    .key_i        (key_i),
    .value_i      (value_i),
    .ttl_i        (ttl_i),
    .now_i        (now_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .found_o      (found_o),
    .read_value_o (read_value_o),
    .evicted_o    (evicted_o),
    .evicted_key_o(evicted_key_o),
    .occupancy_o  (occupancy_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  // cache shadow
  logic        shadow_valid [DEPTH];
  logic [31:0] shadow_key [DEPTH];
  logic [31:0] shadow_data [DEPTH];
  logic [30:0] shadow_deadline [DEPTH];
  logic [31:0] shadow_stamp [DEPTH];
  logic [31:0] shadow_counter;
  logic [4:0]  shadow_count;
  logic [4:0]  shadow_capacity;

  cache_result_t pending_results[$];
  int unsigned   error_count;
  int unsigned   idle_cycles;
  logic          beat_seen;
  logic          result_taken;
  int unsigned   hold_off_cycles;
  logic          sender_no_gaps;
  logic          receiver_no_stalls;
  logic [30:0]   clock_now;
  logic [31:0]   key_pool [24];

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  function automatic int find_slot(logic [31:0] k);
    for (int i = 0; i < DEPTH; i++) begin
      if (shadow_valid[i] && shadow_key[i] == k) return i;
    end
    return -1;
  endfunction

  function automatic void drop_expired(logic [30:0] t);
    for (int i = 0; i < DEPTH; i++) begin
      if (shadow_valid[i] && shadow_deadline[i] < t) begin
        shadow_valid[i] = 1'b0;
        shadow_count--;
      end
    end
  endfunction

  function automatic cache_result_t apply_cache_op(fcte_pkg::func_e f, logic [31:0] k,
                                                   logic [31:0] v, logic [31:0] ttl,
                                                   logic [30:0] t);
    cache_result_t r;
    logic [4:0]  cap;
    logic [32:0] sum;
    logic [30:0] deadline;
    logic [31:0] age;
    logic [31:0] best_age;
    int slot;
    int oldest;
    r = '0;
    cap = shadow_capacity;
    if (cap < 1) cap = 5'd1;
    if (cap > DEPTH) cap = 5'(DEPTH);
    case (f)
      fcte_pkg::FUNC_GET: begin
        drop_expired(t);
        slot = find_slot(k);
        if (slot >= 0) begin
          r.found = 1'b1;
          r.read_value = shadow_data[slot];
        end
      end
      fcte_pkg::FUNC_PUT: begin
        drop_expired(t);
        sum = {2'b0, t} + {1'b0, ttl};
        if (ttl[31]) deadline = fcte_pkg::NEVER_DEADLINE;
        else if (sum > {2'b0, fcte_pkg::NEVER_DEADLINE}) deadline = fcte_pkg::NEVER_DEADLINE;
        else deadline = sum[30:0];
        slot = find_slot(k);
        if (slot >= 0) begin
          shadow_data[slot] = v;
          shadow_deadline[slot] = deadline;
        end else begin
          if (shadow_count + 1 > cap) begin
            oldest = -1;
            best_age = '0;
            for (int i = 0; i < DEPTH; i++) begin
              if (shadow_valid[i]) begin
                age = shadow_counter - shadow_stamp[i];
                if (oldest < 0 || age > best_age) begin
                  oldest = i;
                  best_age = age;
                end
              end
            end
            if (oldest >= 0) begin
              shadow_valid[oldest] = 1'b0;
              shadow_count--;
              r.evicted = 1'b1;
              r.evicted_key = shadow_key[oldest];
            end
          end
          for (int i = 0; i < DEPTH; i++) begin
            if (!shadow_valid[i]) begin
              shadow_valid[i] = 1'b1;
              shadow_key[i] = k;
              shadow_data[i] = v;
              shadow_deadline[i] = deadline;
              shadow_stamp[i] = shadow_counter;
              shadow_counter++;
              shadow_count++;
              break;
            end
          end
        end
      end
      fcte_pkg::FUNC_DEL: begin
        slot = find_slot(k);
        if (slot >= 0) begin
          shadow_valid[slot] = 1'b0;
          shadow_count--;
          r.found = 1'b1;
        end
      end
      default: begin
        for (int i = 0; i < DEPTH; i++) shadow_valid[i] = 1'b0;
        shadow_count = '0;
      end
    endcase
    r.occupancy = shadow_count;
    return r;
  endfunction

  task automatic send_item(fcte_pkg::func_e f, logic [31:0] k, logic [31:0] v,
                           logic [31:0] ttl, logic [30:0] t);
    int unsigned gap;
    gap = sender_no_gaps ? 0 : $urandom_range(0, 8);
    repeat (gap) @(negedge clk_i);
    in_valid_i = 1'b1;
    func_i = f;
    key_i = k;
    value_i = v;
    ttl_i = ttl;
    now_i = t;
    do @(posedge clk_i); while (!in_ready_o);
    pending_results.push_back(apply_cache_op(f, k, v, ttl, t));
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  task automatic write_capacity(logic [4:0] cap);
    wait (pending_results.size() == 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_data_i = cap;
    do @(posedge clk_i); while (!cfg_ready_o);
    shadow_capacity = cap;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic check_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
    if (exp_val !== act_val) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_val, act_val);
      error_count++;
    end
  endtask

  // result checker
  always @(posedge clk_i) begin
    cache_result_t exp_r;
    if (rst_ni && out_valid_o && out_ready_i) begin
      result_taken <= 1'b1;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result beat: expected none, actual occupancy %0d",
                 $time, occupancy_o);
        error_count++;
      end else begin
        exp_r = pending_results.pop_front();
        check_field("found", exp_r.found, found_o);
        check_field("read_value", exp_r.read_value, read_value_o);
        check_field("evicted", exp_r.evicted, evicted_o);
        check_field("evicted_key", exp_r.evicted_key, evicted_key_o);
        check_field("occupancy", exp_r.occupancy, occupancy_o);
      end
    end else begin
      result_taken <= 1'b0;
    end
  end

  // receiver readiness
  initial begin
    int unsigned stall;
    stall = 0;
    forever begin
      @(negedge clk_i);
      if (result_taken) stall = receiver_no_stalls ? 0 : $urandom_range(0, 8);
      if (hold_off_cycles > 0) begin
        hold_off_cycles--;
        out_ready_i = 1'b0;
      end else if (stall > 0) begin
        stall--;
        out_ready_i = 1'b0;
      end else begin
        out_ready_i = 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    beat_seen = (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
                (cfg_valid_i && cfg_ready_o);
    if (beat_seen || !rst_ni) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("** fifo_cache_with_ttl_expiry_top: FAILED **");
      $finish;
    end
  end

  function automatic logic [31:0] pick_key();
    if ($urandom_range(0, 9) == 0) return $urandom;
    return key_pool[$urandom_range(0, 23)];
  endfunction

  function automatic logic [31:0] pick_ttl();
    case ($urandom_range(0, 9))
      0, 1:    return $urandom | 32'h8000_0000;
      2:       return $urandom;
      3:       return 32'h7FFF_FFFF - $urandom_range(0, 5);
      default: return $urandom_range(0, 12);
    endcase
  endfunction

  function automatic fcte_pkg::func_e pick_func();
    case ($urandom_range(0, 19))
      0:                      return fcte_pkg::FUNC_CLR;
      1, 2, 3:                return fcte_pkg::FUNC_DEL;
      4, 5, 6, 7, 8, 9, 10:   return fcte_pkg::FUNC_GET;
      default:                return fcte_pkg::FUNC_PUT;
    endcase
  endfunction

  task automatic test_directed();
    send_item(fcte_pkg::FUNC_GET, 32'h0, 32'h0, 32'sh0, 31'd0);
    send_item(fcte_pkg::FUNC_PUT, 32'h0, 32'h0, 32'sh0, 31'd0);
    send_item(fcte_pkg::FUNC_GET, 32'h0, 32'h0, 32'sh0, 31'd0);
    send_item(fcte_pkg::FUNC_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'sh7FFF_FFFF,
              31'h7FFF_FFFF);
    send_item(fcte_pkg::FUNC_PUT, 32'h1234, 32'hA5A5_5A5A, 32'h8000_0000, 31'd5);
    send_item(fcte_pkg::FUNC_PUT, 32'h55, 32'h11, 32'd3, 31'd5);
    send_item(fcte_pkg::FUNC_GET, 32'h55, 32'h0, 32'd0, 31'd8);
    send_item(fcte_pkg::FUNC_PUT, 32'h55, 32'h22, 32'd10, 31'd8);
    send_item(fcte_pkg::FUNC_GET, 32'h55, 32'h0, 32'd0, 31'd18);
    send_item(fcte_pkg::FUNC_PUT, 32'h66, 32'h33, 32'd1, 31'd18);
    send_item(fcte_pkg::FUNC_DEL, 32'h66, 32'h0, 32'd0, 31'd100);
    send_item(fcte_pkg::FUNC_PUT, 32'h77, 32'h44, 32'd0, 31'd20);
    send_item(fcte_pkg::FUNC_GET, 32'h77, 32'h0, 32'd0, 31'd21);
    send_item(fcte_pkg::FUNC_DEL, 32'h77, 32'h0, 32'd0, 31'd21);
    send_item(fcte_pkg::FUNC_DEL, 32'h1234, 32'h0, 32'd0, 31'd21);
    send_item(fcte_pkg::FUNC_GET, 32'h1234, 32'h0, 32'd0, 31'h7FFF_FFFF);
    send_item(fcte_pkg::FUNC_PUT, 32'h88, 32'hFFFF_0000, 32'sh7FFF_FFFF, 31'h7FFF_FFF0);
    send_item(fcte_pkg::FUNC_GET, 32'h88, 32'h0, 32'sh0, 31'h7FFF_FFFF);
    send_item(fcte_pkg::FUNC_CLR, 32'h0, 32'h0, 32'sh0, 31'd0);
    send_item(fcte_pkg::FUNC_GET, 32'hFFFF_FFFF, 32'h0, 32'sh0, 31'd0);
    for (int i = 0; i < 5; i++) begin
      send_item(fcte_pkg::FUNC_PUT, 32'h100 + i, 32'h200 + i, -32'sd1, 31'd30);
    end
  endtask

  task automatic test_capacity();
    logic [4:0] caps [5] = '{5'd1, 5'd0, 5'd31, 5'd16, 5'd4};
    foreach (caps[c]) begin
      write_capacity(caps[c]);
      for (int i = 0; i < 20; i++) begin
        send_item(fcte_pkg::FUNC_PUT, 32'h300 + c * 32 + i, $urandom, -32'sd1, 31'd40);
      end
      send_item(fcte_pkg::FUNC_CLR, 32'h0, 32'h0, 32'sh0, 31'd40);
    end
    write_capacity(5'd16);
    for (int i = 0; i < 10; i++) begin
      send_item(fcte_pkg::FUNC_PUT, 32'h400 + i, $urandom, -32'sd1, 31'd50);
    end
    write_capacity(5'd3);
    send_item(fcte_pkg::FUNC_PUT, 32'h500, 32'h1, -32'sd1, 31'd50);
    send_item(fcte_pkg::FUNC_PUT, 32'h501, 32'h2, -32'sd1, 31'd50);
    send_item(fcte_pkg::FUNC_DEL, 32'h405, 32'h0, 32'sd0, 31'd50);
    send_item(fcte_pkg::FUNC_PUT, 32'h405, 32'h3, 32'sd5, 31'd50);
  endtask

  task automatic test_random();
    fcte_pkg::func_e f;
    logic [4:0] caps [6] = '{5'd16, 5'd2, 5'd8, 5'd1, 5'd31, 5'd5};
    for (int n = 0; n < 1000; n++) begin
      if (n % 170 == 0) write_capacity(caps[(n / 170) % 6]);
      if (n % 60 == 0) begin
        sender_no_gaps = ($urandom_range(0, 3) == 0);
        receiver_no_stalls = ($urandom_range(0, 3) == 0);
      end
      if ($urandom_range(0, 39) == 0) clock_now = 31'($urandom);
      else if (clock_now < 31'h7FFF_FFF0) clock_now = clock_now + 31'($urandom_range(0, 3));
      f = pick_func();
      send_item(f, pick_key(), $urandom, pick_ttl(), clock_now);
    end
  endtask

  task automatic test_backpressure();
    write_capacity(5'd16);
    sender_no_gaps = 1'b1;
    hold_off_cycles = 300;
    for (int i = 0; i < 12; i++) begin
      send_item(fcte_pkg::FUNC_PUT, key_pool[i], $urandom, 32'sd100, 31'd10);
    end
    sender_no_gaps = 1'b0;
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    func_i = fcte_pkg::FUNC_GET;
    key_i = '0;
    value_i = '0;
    ttl_i = '0;
    now_i = '0;
    out_ready_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    error_count = 0;
    hold_off_cycles = 0;
    sender_no_gaps = 1'b0;
    receiver_no_stalls = 1'b0;
    clock_now = '0;
    for (int i = 0; i < DEPTH; i++) shadow_valid[i] = 1'b0;
    shadow_counter = '0;
    shadow_count = '0;
    shadow_capacity = 5'd16;
    foreach (key_pool[i]) key_pool[i] = (i < 2) ? {32{i[0]}} : $urandom;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed();
    test_capacity();
    test_backpressure();
    test_random();

    wait (pending_results.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("** fifo_cache_with_ttl_expiry_top: PASSED **");
    end else begin
      $display("** fifo_cache_with_ttl_expiry_top: FAILED **");
    end
    $finish;
  end

endmodule

// File: files.f
design/fcte_pkg.sv
design/fcte_store.sv
design/fifo_cache_with_ttl_expiry_top.sv
tb/sv/tb_fifo_cache_with_ttl_expiry_top.sv
